### rtl/core/aesp_pkg.sv
// Shared types and constants for the ANSI escape sequence parser.
// No dependencies; every rtl/core module refers to it by scoped names.
`timescale 1ns / 1ps

package aesp_pkg;

    // Parameter slots and their width
    localparam int NUM_ARGS  = 5;
    localparam int ARG_WIDTH = 16;
    localparam int OUT_ARGS  = 5;
    localparam int ARG_OUT_W = 16;
    localparam int IDX_W     = $clog2(NUM_ARGS + 1);
    localparam int SLOT_W    = $clog2(NUM_ARGS);

    localparam logic [ARG_WIDTH-1:0] ARG_MAX = '1;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_DIGIT_LO = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUEST    = 8'h3F;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;

    localparam logic [ARG_WIDTH-1:0] MODE_VT52   = ARG_WIDTH'(2);
    localparam logic [ARG_WIDTH-1:0] MODE_INSERT = ARG_WIDTH'(4);
    localparam logic [ARG_WIDTH-1:0] MODE_RESET  = ARG_WIDTH'(9);

    typedef enum logic [1:0] {
        PH_READY,
        PH_ESC,
        PH_SEQ
    } t_phase;

    typedef enum logic [2:0] {
        EV_ABSORBED = 3'd0,
        EV_PRINT    = 3'd1,
        EV_CONTROL  = 3'd2,
        EV_ESCAPE   = 3'd3,
        EV_CSI      = 3'd4,
        EV_CHARSET  = 3'd5
    } t_event;

    // sequencer -> argument store
    typedef struct packed {
        logic       clear;
        logic       digit_en;
        logic       semi_en;
        logic [3:0] digit;
    } t_arg_ctrl;

    // argument store -> sequencer / result
    typedef struct packed {
        logic [NUM_ARGS-1:0][ARG_WIDTH-1:0] args;
        logic [IDX_W-1:0]                   idx;
    } t_arg_stat;

endpackage

### rtl/core/aesp_args.sv
// Parameter store: NUM_ARGS saturating decimal accumulators and the slot index.
// Depends on aesp_pkg.
`timescale 1ns / 1ps

module aesp_args (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  aesp_pkg::t_arg_ctrl i_ctrl,
    output aesp_pkg::t_arg_stat o_stat
);

    logic [aesp_pkg::ARG_WIDTH-1:0] r_args [aesp_pkg::NUM_ARGS];
    logic [aesp_pkg::IDX_W-1:0]     r_idx;

    logic [aesp_pkg::SLOT_W-1:0]    slot;
    logic                           slot_ok;
    logic [aesp_pkg::ARG_WIDTH-1:0] cur;
    logic [aesp_pkg::ARG_WIDTH+3:0] prod;
    logic [aesp_pkg::ARG_WIDTH-1:0] n_val;

    assign slot    = r_idx[aesp_pkg::SLOT_W-1:0];
    assign slot_ok = (r_idx < aesp_pkg::IDX_W'(aesp_pkg::NUM_ARGS));
    assign cur     = r_args[slot];

    // v*10 + d as two shifts and two adds, then clamp
    always_comb begin
        prod = ({4'b0, cur} << 3) + ({4'b0, cur} << 1)
             + {{aesp_pkg::ARG_WIDTH{1'b0}}, i_ctrl.digit};
        if (prod > {4'b0, aesp_pkg::ARG_MAX}) begin
            n_val = aesp_pkg::ARG_MAX;
        end else begin
            n_val = prod[aesp_pkg::ARG_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < aesp_pkg::NUM_ARGS; i++) begin
                r_args[i] <= '0;
            end
            r_idx <= '0;
        end else if (i_en) begin
            if (i_ctrl.clear) begin
                for (int i = 0; i < aesp_pkg::NUM_ARGS; i++) begin
                    r_args[i] <= '0;
                end
                r_idx <= '0;
            end else begin
                if (i_ctrl.digit_en && slot_ok) begin
                    r_args[slot] <= n_val;
                end
                if (i_ctrl.semi_en && slot_ok) begin
                    r_idx <= r_idx + aesp_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < aesp_pkg::NUM_ARGS; i++) begin
            o_stat.args[i] = r_args[i];
        end
        o_stat.idx = r_idx;
    end

endmodule

### rtl/core/aesp_fsm.sv
// Escape sequencer: phase, sequence flags, VT52 and insert modes; byte decode.
// Depends on aesp_pkg.
`timescale 1ns / 1ps

module aesp_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    input  aesp_pkg::t_arg_stat i_stat,
    output aesp_pkg::t_arg_ctrl o_ctrl,
    output aesp_pkg::t_event    o_event,
    output logic [7:0]          o_code,
    output logic                o_fin,
    output logic                o_private,
    output logic                o_space,
    output logic                o_vt52,
    output logic                o_insert
);

    aesp_pkg::t_phase r_phase, n_phase;
    logic r_charset, n_charset;
    logic r_quest, n_quest;
    logic r_space, n_space;
    logic r_vt52, n_vt52;
    logic r_insert, n_insert;

    logic is_digit, is_final, esc_ok;
    logic [aesp_pkg::ARG_WIDTH-1:0] p0;

    assign p0 = i_stat.args[0];

    // byte classes
    always_comb begin
        is_digit = (i_byte >= aesp_pkg::CH_DIGIT_LO) && (i_byte <= aesp_pkg::CH_DIGIT_HI);
        is_final = (i_byte >= aesp_pkg::CH_FINAL_LO) && (i_byte < aesp_pkg::CH_TILDE);
        esc_ok   = 1'b0;
        if (i_byte inside {"c", "F", "G"}) begin
            esc_ok = 1'b1;
        end else if (!r_vt52) begin
            esc_ok = i_byte inside {"7", "8", "D", "M", "E"};
        end else begin
            esc_ok = i_byte inside {"<", "A", "B", "C", "D", "H", "I", "J", "K", "Z"};
        end
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_charset = r_charset;
        n_quest   = r_quest;
        n_space   = r_space;
        n_vt52    = r_vt52;
        n_insert  = r_insert;
        case (r_phase)
            aesp_pkg::PH_READY: begin
                if (i_byte == aesp_pkg::CH_ESC) begin
                    n_phase = aesp_pkg::PH_ESC;
                end
            end
            aesp_pkg::PH_ESC: begin
                n_phase   = aesp_pkg::PH_READY;
                n_charset = 1'b0;
                n_quest   = 1'b0;
                n_space   = 1'b0;
                if (i_byte == aesp_pkg::CH_LBRACKET) begin
                    n_phase = aesp_pkg::PH_SEQ;
                end else if (i_byte == aesp_pkg::CH_LPAREN) begin
                    n_phase   = aesp_pkg::PH_SEQ;
                    n_charset = 1'b1;
                end else if (i_byte == "c") begin
                    n_vt52   = 1'b0;
                    n_insert = 1'b0;
                end else if (i_byte == "<" && r_vt52) begin
                    n_vt52 = 1'b0;
                end
            end
            aesp_pkg::PH_SEQ: begin
                if ((is_digit && r_charset) || is_final) begin
                    n_phase   = aesp_pkg::PH_READY;
                    n_charset = 1'b0;
                    n_quest   = 1'b0;
                    n_space   = 1'b0;
                    // mode set/reset only for CSI finals in VT100 mode
                    if (is_final && !r_charset && !r_vt52) begin
                        if (i_byte == "h") begin
                            if (r_quest) begin
                                if (p0 == aesp_pkg::MODE_RESET) begin
                                    n_vt52   = 1'b0;
                                    n_insert = 1'b0;
                                end
                            end else if (p0 == aesp_pkg::MODE_INSERT) begin
                                n_insert = 1'b1;
                            end
                        end else if (i_byte == "l") begin
                            if (r_quest) begin
                                if (p0 == aesp_pkg::MODE_VT52) begin
                                    n_vt52 = 1'b1;
                                end else if (p0 == aesp_pkg::MODE_RESET) begin
                                    n_vt52   = 1'b0;
                                    n_insert = 1'b0;
                                end
                            end else if (p0 == aesp_pkg::MODE_INSERT) begin
                                n_insert = 1'b0;
                            end
                        end
                    end
                end else if (i_byte == aesp_pkg::CH_QUEST) begin
                    n_quest = 1'b1;
                end else if (i_byte == aesp_pkg::CH_SPACE) begin
                    n_space = 1'b1;
                end
            end
            default: begin
                n_phase = aesp_pkg::PH_READY;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_event        = aesp_pkg::EV_ABSORBED;
        o_code         = '0;
        o_fin          = 1'b0;
        o_ctrl.clear    = 1'b0;
        o_ctrl.digit_en = 1'b0;
        o_ctrl.semi_en  = 1'b0;
        o_ctrl.digit    = 4'(i_byte - aesp_pkg::CH_DIGIT_LO);
        case (r_phase)
            aesp_pkg::PH_READY: begin
                if (i_byte >= aesp_pkg::CH_SPACE) begin
                    o_event = aesp_pkg::EV_PRINT;
                    o_code  = i_byte;
                end else if (i_byte != aesp_pkg::CH_ESC) begin
                    o_event = aesp_pkg::EV_CONTROL;
                    o_code  = i_byte;
                end
            end
            aesp_pkg::PH_ESC: begin
                o_ctrl.clear = 1'b1;
                if (i_byte != aesp_pkg::CH_LBRACKET && i_byte != aesp_pkg::CH_LPAREN
                        && esc_ok) begin
                    o_event = aesp_pkg::EV_ESCAPE;
                    o_code  = i_byte;
                end
            end
            aesp_pkg::PH_SEQ: begin
                if ((is_digit && r_charset) || is_final) begin
                    o_event      = r_charset ? aesp_pkg::EV_CHARSET : aesp_pkg::EV_CSI;
                    o_code       = i_byte;
                    o_fin        = 1'b1;
                    o_ctrl.clear = 1'b1;
                end else if (is_digit) begin
                    o_ctrl.digit_en = 1'b1;
                end else if (i_byte == aesp_pkg::CH_SEMI) begin
                    o_ctrl.semi_en = 1'b1;
                end
            end
            default: begin
                o_ctrl.clear = 1'b1;
            end
        endcase
    end

    assign o_private = o_fin & r_quest;
    assign o_space   = o_fin & r_space;
    assign o_vt52    = n_vt52;
    assign o_insert  = n_insert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= aesp_pkg::PH_READY;
            r_charset <= 1'b0;
            r_quest   <= 1'b0;
            r_space   <= 1'b0;
            r_vt52    <= 1'b0;
            r_insert  <= 1'b0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_charset <= n_charset;
            r_quest   <= n_quest;
            r_space   <= n_space;
            r_vt52    <= n_vt52;
            r_insert  <= n_insert;
        end
    end

endmodule

### rtl/core/ansi_escape_sequence_parser_top.sv
// Top level of the ANSI escape sequence parser: input register, sequencer,
// parameter store and result register. Depends on aesp_pkg, aesp_args, aesp_fsm.
//
//  channel   dir  tdata                          tuser
//  s_axis    in   [7:0] byte_in                  -
//  m_axis    out  code, args, flags (see port)   [2:0] event_res
//
// One byte per cycle sustained while results are taken; a byte's result word is
// registered from the input register into the result register, with the whole
// decode and the x10 accumulate between them.
// Synchronous active-low reset returns to the ready phase, VT100, insert off,
// all parameters zero. A stalled result holds in the result register while the
// input register still takes a byte; the input stalls only when both are full
// and the result is not taken.
`timescale 1ns / 1ps

module ansi_escape_sequence_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // code[7:0], arg_zero..arg_four [87:8],
                                        // arg_last_index[90:88], private_flag[91],
                                        // space_flag[92], vt52_active[93],
                                        // insert_active[94], zero[95]
    output logic [2:0]  m_axis_tuser    // [2:0] event_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    logic [2:0]  r_out_event;
    logic [95:0] r_out_data;
    logic        advance;

    aesp_pkg::t_arg_ctrl arg_ctrl;
    aesp_pkg::t_arg_stat arg_stat;
    aesp_pkg::t_event    ev;
    logic [7:0]          code;
    logic                fin, priv, spc, vt52, ins;

    logic [aesp_pkg::OUT_ARGS-1:0][aesp_pkg::ARG_OUT_W-1:0] arg_out;
    logic [aesp_pkg::IDX_W+2:0] idx_ext;
    logic [2:0]                 last_idx;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    aesp_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_byte    (r_in_byte),
        .i_stat    (arg_stat),
        .o_ctrl    (arg_ctrl),
        .o_event   (ev),
        .o_code    (code),
        .o_fin     (fin),
        .o_private (priv),
        .o_space   (spc),
        .o_vt52    (vt52),
        .o_insert  (ins)
    );

    aesp_args u_args (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_ctrl  (arg_ctrl),
        .o_stat  (arg_stat)
    );

    // parameters fit into the 16-bit result slots; slots past NUM_ARGS read zero
    genvar g;
    generate
        for (g = 0; g < aesp_pkg::OUT_ARGS; g++) begin : g_arg
            if (g < aesp_pkg::NUM_ARGS) begin : g_used
                logic [aesp_pkg::ARG_WIDTH+aesp_pkg::ARG_OUT_W-1:0] ext;
                assign ext        = {{aesp_pkg::ARG_OUT_W{1'b0}}, arg_stat.args[g]};
                assign arg_out[g] = fin ? ext[aesp_pkg::ARG_OUT_W-1:0] : '0;
            end else begin : g_unused
                assign arg_out[g] = '0;
            end
        end
    endgenerate

    assign idx_ext  = {3'b0, arg_stat.idx};
    assign last_idx = !fin ? 3'd0 :
                      (idx_ext > (aesp_pkg::IDX_W + 3)'(7)) ? 3'd7 : idx_ext[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= ev;
            r_out_data  <= {1'b0, ins, vt52, spc, priv, last_idx,
                            arg_out[4], arg_out[3], arg_out[2], arg_out[1], arg_out[0],
                            code};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_event;

    // a waiting input word is neither lost nor overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("input word dropped while stalled");

    // absorbed bytes carry no code and no parameters
    a_absorbed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_event == aesp_pkg::EV_ABSORBED
            |-> r_out_data[92:0] == '0)
        else $error("absorbed event with payload");

    // the semicolon count never passes the slot count
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arg_stat.idx <= aesp_pkg::IDX_W'(aesp_pkg::NUM_ARGS))
        else $error("argument index out of range");

endmodule

### sim/testbench.sv
// Self-checking bench for ansi_escape_sequence_parser_top: drives a byte stream,
// predicts each decoded word in a behavioral decoder and compares per field.
// Depends on aesp_pkg and the rtl/core sources.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_BYTES = 1050;
    localparam int          IDLE_PCT     = 36;

    // m_axis_tdata layout, lowest field last
    typedef struct packed {
        logic                 pad;
        logic                 ins;
        logic                 vt52;
        logic                 spc;
        logic                 priv;
        logic [2:0]           last_idx;
        logic [4:0][15:0]     args;
        logic [7:0]           code;
    } t_word_fields;

    typedef struct packed {
        aesp_pkg::t_event ev;
        t_word_fields     f;
    } t_parsed_word;

    typedef struct packed {
        logic [7:0] value;
        logic       hold;   // wait for all words to drain before sending
    } t_tx_byte;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    t_tx_byte     pending_bytes[$];
    t_parsed_word expected_words[$];
    bit           hold_next = 1'b0;

    int unsigned bytes_sent   = 0;
    int unsigned words_seen   = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned ev_count[6]  = '{default: 0};
    int unsigned vt52_words   = 0;
    int unsigned insert_words = 0;

    // decoder state
    aesp_pkg::t_phase ph     = aesp_pkg::PH_READY;
    logic        in_charset  = 1'b0;
    logic [15:0] par[aesp_pkg::NUM_ARGS] = '{default: '0};
    logic [2:0]  par_idx     = '0;
    logic        saw_quest   = 1'b0;
    logic        saw_space   = 1'b0;
    logic        vt52        = 1'b0;
    logic        insert      = 1'b0;

    ansi_escape_sequence_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    //--------------------------------------------------------------------
    // decoder
    //--------------------------------------------------------------------
    task automatic clear_seq();
        for (int i = 0; i < aesp_pkg::NUM_ARGS; i++) par[i] = '0;
        par_idx    = '0;
        in_charset = 1'b0;
        saw_quest  = 1'b0;
        saw_space  = 1'b0;
        ph         = aesp_pkg::PH_READY;
    endtask

    task automatic match_escape(input logic [7:0] b, output bit hit);
        if (b == "c") begin
            vt52   = 1'b0;
            insert = 1'b0;
            hit    = 1'b1;
        end else if (b == "F" || b == "G") begin
            hit = 1'b1;
        end else if (!vt52) begin
            hit = (b == "7" || b == "8" || b == "D" || b == "M" || b == "E");
        end else if (b == "<") begin
            vt52 = 1'b0;
            hit  = 1'b1;
        end else begin
            hit = (b == "A" || b == "B" || b == "C" || b == "D" || b == "H" ||
                   b == "I" || b == "J" || b == "K" || b == "Z");
        end
    endtask

    task automatic close_seq(input logic [7:0] fin, input aesp_pkg::t_event ev,
                             inout t_parsed_word w);
        w.ev         = ev;
        w.f.code     = fin;
        for (int i = 0; i < aesp_pkg::OUT_ARGS; i++)
            w.f.args[i] = (i < aesp_pkg::NUM_ARGS) ? par[i] : '0;
        w.f.last_idx = par_idx;
        w.f.priv     = saw_quest;
        w.f.spc      = saw_space;
        // modes only switch on a CSI final while in VT100
        if (ev == aesp_pkg::EV_CSI && !vt52) begin
            if (fin == "h") begin
                if (saw_quest) begin
                    if (par[0] == aesp_pkg::MODE_RESET) begin
                        vt52   = 1'b0;
                        insert = 1'b0;
                    end
                end else if (par[0] == aesp_pkg::MODE_INSERT) begin
                    insert = 1'b1;
                end
            end else if (fin == "l") begin
                if (saw_quest) begin
                    if (par[0] == aesp_pkg::MODE_VT52) begin
                        vt52 = 1'b1;
                    end else if (par[0] == aesp_pkg::MODE_RESET) begin
                        vt52   = 1'b0;
                        insert = 1'b0;
                    end
                end else if (par[0] == aesp_pkg::MODE_INSERT) begin
                    insert = 1'b0;
                end
            end
        end
        clear_seq();
    endtask

    task automatic decode_byte(input logic [7:0] b);
        t_parsed_word w;
        logic [19:0]  acc;
        bit           hit;
        w    = '0;
        w.ev = aesp_pkg::EV_ABSORBED;
        case (ph)
            aesp_pkg::PH_READY: begin
                if (b >= aesp_pkg::CH_SPACE) begin
                    w.ev     = aesp_pkg::EV_PRINT;
                    w.f.code = b;
                end else if (b == aesp_pkg::CH_ESC) begin
                    ph = aesp_pkg::PH_ESC;
                end else begin
                    w.ev     = aesp_pkg::EV_CONTROL;
                    w.f.code = b;
                end
            end
            aesp_pkg::PH_ESC: begin
                if (b == aesp_pkg::CH_LBRACKET) begin
                    clear_seq();
                    ph = aesp_pkg::PH_SEQ;
                end else if (b == aesp_pkg::CH_LPAREN) begin
                    clear_seq();
                    in_charset = 1'b1;
                    ph         = aesp_pkg::PH_SEQ;
                end else begin
                    match_escape(b, hit);
                    if (hit) begin
                        w.ev     = aesp_pkg::EV_ESCAPE;
                        w.f.code = b;
                    end
                    clear_seq();
                end
            end
            default: begin
                if (b >= aesp_pkg::CH_DIGIT_LO && b <= aesp_pkg::CH_DIGIT_HI) begin
                    if (in_charset) begin
                        close_seq(b, aesp_pkg::EV_CHARSET, w);
                    end else if (par_idx < aesp_pkg::NUM_ARGS) begin
                        acc = 20'(par[par_idx]) * 20'd10 + 20'(b - aesp_pkg::CH_DIGIT_LO);
                        par[par_idx] = (acc > 20'(aesp_pkg::ARG_MAX)) ? aesp_pkg::ARG_MAX
                                                                      : acc[15:0];
                    end
                end else if (b == aesp_pkg::CH_SEMI) begin
                    if (par_idx < aesp_pkg::NUM_ARGS) par_idx = par_idx + 3'd1;
                end else if (b == aesp_pkg::CH_QUEST) begin
                    saw_quest = 1'b1;
                end else if (b == aesp_pkg::CH_SPACE) begin
                    saw_space = 1'b1;
                end else if (b >= aesp_pkg::CH_FINAL_LO && b < aesp_pkg::CH_TILDE) begin
                    close_seq(b, in_charset ? aesp_pkg::EV_CHARSET : aesp_pkg::EV_CSI, w);
                end
            end
        endcase
        w.f.vt52 = vt52;
        w.f.ins  = insert;
        expected_words.push_back(w);
    endtask

    //--------------------------------------------------------------------
    // stimulus helpers
    //--------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        t_tx_byte t;
        t.value   = b;
        t.hold    = hold_next;
        hold_next = 1'b0;
        pending_bytes.push_back(t);
    endtask

    task automatic queue_str(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_digits(input int n);
        for (int i = 0; i < n; i++)
            queue_byte(aesp_pkg::CH_DIGIT_LO + 8'($urandom_range(0, 9)));
    endtask

    // a byte that a sequence in progress skips over
    function automatic logic [7:0] skipped_byte();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0: b = 8'($urandom_range(8'h00, 8'h1F));
            1: b = aesp_pkg::CH_TILDE;
            2: b = 8'($urandom_range(8'h7F, 8'hFF));
            3: b = 8'($urandom_range(8'h3C, 8'h3E));
            default: begin
                b = 8'($urandom_range(8'h21, 8'h2F));
                if (b == aesp_pkg::CH_LPAREN && $urandom_range(0, 1)) b = 8'h3A;
            end
        endcase
        return b;
    endfunction

    function automatic logic [7:0] final_byte();
        return 8'($urandom_range(aesp_pkg::CH_FINAL_LO, aesp_pkg::CH_TILDE - 8'd1));
    endfunction

    task automatic queue_csi();
        int nparams;
        queue_byte(aesp_pkg::CH_ESC);
        queue_byte(aesp_pkg::CH_LBRACKET);
        if ($urandom_range(0, 1)) queue_byte(aesp_pkg::CH_QUEST);
        nparams = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
        for (int p = 0; p < nparams; p++) begin
            if (p > 0) queue_byte(aesp_pkg::CH_SEMI);
            if (p == 0 && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 2))
                    0: queue_str("2");
                    1: queue_str("4");
                    default: queue_str("9");
                endcase
            end else begin
                queue_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                         : $urandom_range(0, 3));
            end
        end
        if ($urandom_range(0, 5) == 0) queue_byte(aesp_pkg::CH_SPACE);
        if ($urandom_range(0, 7) == 0) queue_byte(skipped_byte());
        case ($urandom_range(0, 3))
            0: queue_str("h");
            1: queue_str("l");
            default: queue_byte(final_byte());
        endcase
    endtask

    task automatic queue_charset();
        queue_byte(aesp_pkg::CH_ESC);
        queue_byte(aesp_pkg::CH_LPAREN);
        case ($urandom_range(0, 9))
            0: queue_byte(skipped_byte());
            1: queue_byte(aesp_pkg::CH_QUEST);
            2: queue_byte(aesp_pkg::CH_SEMI);
            3: queue_byte(aesp_pkg::CH_SPACE);
            default: ;
        endcase
        if ($urandom_range(0, 1)) queue_digits(1);
        else queue_byte(final_byte());
    endtask

    task automatic queue_mode_switch();
        case ($urandom_range(0, 5))
            0: queue_str("\033[?2l");
            1: queue_str("\033[?9h");
            2: queue_str("\033[?9l");
            3: queue_str("\033[4h");
            4: queue_str("\033[4l");
            default: queue_str("\033<");
        endcase
    endtask

    task automatic queue_single_escape();
        string cmds;
        cmds = "cFG78DMEABCHIJKZ<";
        queue_byte(aesp_pkg::CH_ESC);
        if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom_range(0, 255)));
        else queue_byte(cmds[$urandom_range(0, cmds.len() - 1)]);
    endtask

    //--------------------------------------------------------------------
    // driver
    //--------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tx_byte nxt;
        bit       tx_calm;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata);
                bytes_sent++;
            end
            tx_calm = (bytes_sent >= 500 && bytes_sent < 700);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_bytes.size() != 0 &&
                    (tx_calm || $urandom_range(0, 99) >= IDLE_PCT) &&
                    !(pending_bytes[0].hold && expected_words.size() != 0)) begin
                    nxt = pending_bytes.pop_front();
                    s_axis_tdata  <= nxt.value;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // monitor
    //--------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [15:0] want, got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in word %0d, %s: expected 0x%0h, got 0x%0h",
                         words_seen, name, want, got);
        end
    endtask

    task automatic check_word(input logic [2:0] user, input logic [95:0] data);
        t_parsed_word want;
        t_word_fields got;
        got = data;
        words_seen++;
        if (user < 3'd6) ev_count[user]++;
        if (got.vt52) vt52_words++;
        if (got.ins) insert_words++;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word %0d: tuser 0x%0h tdata 0x%0h",
                         words_seen, user, data);
            return;
        end
        want = expected_words.pop_front();
        compare_field("event", 16'(want.ev), 16'(user));
        compare_field("code", 16'(want.f.code), 16'(got.code));
        for (int i = 0; i < aesp_pkg::OUT_ARGS; i++)
            compare_field($sformatf("arg%0d", i), want.f.args[i], got.args[i]);
        compare_field("last_idx", 16'(want.f.last_idx), 16'(got.last_idx));
        compare_field("private", 16'(want.f.priv), 16'(got.priv));
        compare_field("space", 16'(want.f.spc), 16'(got.spc));
        compare_field("vt52", 16'(want.f.vt52), 16'(got.vt52));
        compare_field("insert", 16'(want.f.ins), 16'(got.ins));
        compare_field("pad", 16'(want.f.pad), 16'(got.pad));
    endtask

    always @(posedge i_clk) begin
        bit rx_calm;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tuser, m_axis_tdata);
            rx_calm = (words_seen >= 500 && words_seen < 700);
            m_axis_tready <= rx_calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    //--------------------------------------------------------------------
    // watchdog
    //--------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_count, expected_words.size());
        $display("testbench failed");
        $finish;
    end

    //--------------------------------------------------------------------
    // stimulus and end of run
    //--------------------------------------------------------------------
    initial begin
        int base;
        int kind;
        int total;

        // directed: byte extremes, mode switches, both escape sets, charset,
        // unknown escape, full reset
        queue_byte(8'h00);
        queue_byte(8'h1F);
        queue_byte(aesp_pkg::CH_SPACE);
        queue_byte(8'hFF);
        queue_str("\033[4h");
        queue_str("\033[?2l");
        queue_str("\033A");
        queue_str("\033<");
        queue_str("\033(0");
        queue_str("\033x");
        queue_str("\033c");

        base      = pending_bytes.size();
        hold_next = 1'b1;
        while (pending_bytes.size() - base < RANDOM_BYTES) begin
            if (pending_bytes.size() - base >= RANDOM_BYTES / 2 &&
                pending_bytes.size() - base < RANDOM_BYTES / 2 + 8)
                hold_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                queue_byte(8'($urandom_range(0, 255)));
            end else if (kind < 55) begin
                queue_csi();
            end else if (kind < 62) begin
                queue_mode_switch();
            end else if (kind < 76) begin
                queue_single_escape();
            end else if (kind < 86) begin
                queue_charset();
            end else if (kind < 93) begin
                // sequence cut short by a random byte
                queue_byte(aesp_pkg::CH_ESC);
                if ($urandom_range(0, 1)) queue_byte(aesp_pkg::CH_LBRACKET);
                queue_digits($urandom_range(0, 2));
                queue_byte(8'($urandom_range(0, 255)));
            end else begin
                queue_byte(aesp_pkg::CH_ESC);
                queue_byte(8'($urandom_range(0, 255)));
            end
        end
        total = pending_bytes.size();

        while (bytes_sent < total) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d bytes, %0d words: print %0d, control %0d, escape %0d, csi %0d, charset %0d",
                 bytes_sent, words_seen, ev_count[aesp_pkg::EV_PRINT],
                 ev_count[aesp_pkg::EV_CONTROL], ev_count[aesp_pkg::EV_ESCAPE],
                 ev_count[aesp_pkg::EV_CSI], ev_count[aesp_pkg::EV_CHARSET]);
        $display("absorbed %0d, words in vt52 %0d, words with insert on %0d, mismatches %0d",
                 ev_count[aesp_pkg::EV_ABSORBED], vt52_words, insert_words, mismatches);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
